// File: hdl/chgw_pkg.sv
// Shared package of the gift-wrapping convex hull block.
// Holds default sizes, field widths, status codes and the scan control structs.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package chgw_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int FIELD_W  = 16;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  // A hull needs at least this many points.
  localparam int MIN_POINTS = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OPEN = 2'd2;

  // Controller to turn pipeline.
  typedef struct packed {
    logic issue;
    logic flush;
  } scan_ctl_t;

  // Turn pipeline to controller.
  typedef struct packed {
    logic valid;
    logic cw;
    logic busy;
  } scan_stat_t;

endpackage

`default_nettype wire

// File: hdl/chgw_if.sv
// Channel interfaces of the convex hull block: point input and hull result.
// Each carries valid, ready and the payload; depends on chgw_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface chgw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [chgw_pkg::FIELD_W-1:0] x;
  logic signed [chgw_pkg::FIELD_W-1:0] y;
  logic                                last;

  modport source (output valid, output x, output y, output last, input ready);
  modport sink   (input valid, input x, input y, input last, output ready);
endinterface

interface chgw_out_if;
  logic                               valid;
  logic                               ready;
  logic [chgw_pkg::IDX_W-1:0]         vertex_index;
  logic [chgw_pkg::STATUS_W-1:0]      status;
  logic                               end_of_hull;

  modport source (output valid, output vertex_index, output status, output end_of_hull,
                  input ready);
  modport sink   (input valid, input vertex_index, input status, input end_of_hull,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/chgw_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the point store and the hull vertex buffer; depends on chgw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chgw_ram #(
  parameter int WIDTH = 2 * chgw_pkg::COORD_BITS_DEF,
  parameter int DEPTH = chgw_pkg::MAX_POINTS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: hdl/chgw_turn.sv
// Orientation pipeline: tests each scanned point against the current edge p->q.
// Takes point words from the point RAM; depends on chgw_pkg for control structs.
`timescale 1ns / 1ps
`default_nettype none

module chgw_turn #(
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF,
  parameter int AW         = $clog2(chgw_pkg::MAX_POINTS_DEF),
  localparam int DW        = COORD_BITS + 1,
  localparam int PW        = 2 * DW
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire chgw_pkg::scan_ctl_t          ctl,
  input  wire logic        [AW-1:0]         iss_idx,
  input  wire logic        [2*COORD_BITS-1:0] pt_data,
  input  wire logic signed [COORD_BITS-1:0] p_x,
  input  wire logic signed [COORD_BITS-1:0] p_y,
  input  wire logic signed [DW-1:0]         dq_x,
  input  wire logic signed [DW-1:0]         dq_y,
  output chgw_pkg::scan_stat_t              stat,
  output logic             [AW-1:0]         res_idx,
  output logic signed      [COORD_BITS-1:0] res_x,
  output logic signed      [COORD_BITS-1:0] res_y,
  output logic signed      [DW-1:0]         res_dx,
  output logic signed      [DW-1:0]         res_dy
);

  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;

  logic v0_r, v1_r, v2_r;
  logic [AW-1:0] idx0_r, idx1_r, idx2_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [PW-1:0] pa_nxt, pb_nxt, pa_r, pb_r;

  assign pt_x = pt_data[COORD_BITS-1:0];
  assign pt_y = pt_data[2*COORD_BITS-1:COORD_BITS];

  // Stage valid bits; a flush drops everything in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ctl.flush) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= ctl.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Cross product terms of (i - p) x (q - p), compared instead of subtracted.
  assign pa_nxt = dx1_r * dq_y;
  assign pb_nxt = dq_x * dy1_r;

  // Payload stages: read index, offsets from p, then the two products.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      idx0_r <= iss_idx;
    end
    idx1_r <= idx0_r;
    x1_r   <= pt_x;
    y1_r   <= pt_y;
    dx1_r  <= DW'(pt_x) - DW'(p_x);
    dy1_r  <= DW'(pt_y) - DW'(p_y);
    idx2_r <= idx1_r;
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
  end

  // A strictly negative cross product means the turn p -> i -> q is clockwise.
  assign stat.valid = v2_r;
  assign stat.cw    = pa_r < pb_r;
  assign stat.busy  = v0_r | v1_r | v2_r;

  assign res_idx = idx2_r;
  assign res_x   = x2_r;
  assign res_y   = y2_r;
  assign res_dx  = dx2_r;
  assign res_dy  = dy2_r;

endmodule

`default_nettype wire

// File: hdl/convex_hull_gift_wrap.sv
// Top level of the gift-wrapping convex hull block: controller, point RAM, hull buffer.
// Depends on chgw_pkg, chgw_if, chgw_ram and chgw_turn.
`timescale 1ns / 1ps
`default_nettype none

// Points are loaded one per cycle into a point RAM (up to MAX_POINTS; further points are
// dropped). The point marked last starts the walk, and no point is taken until the walk
// and its results are done. For each hull vertex the scan reads the point RAM one entry
// per cycle through a three-stage orientation pipeline that restarts after each candidate
// replacement. Results leave from an output register, each read from the hull buffer in
// S_ERD and loaded in S_EPUT; a set with fewer than three points, or a walk that does
// not close within MAX_POINTS vertices, gives a single status result. The start vertex
// is found during loading at no cost.
module convex_hull_gift_wrap #(
  parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  chgw_in_if.sink    in_ch,
  chgw_out_if.source out_ch
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;
  localparam int PTW = 2 * CB;
  localparam int IW  = chgw_pkg::IDX_W;

  // Controller states.
  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_FEW  = 4'd1;
  localparam logic [3:0] S_OPEN = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_VTX  = 4'd4;
  localparam logic [3:0] S_QLD  = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_EPUT = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [CW-1:0] count_r, n_r, iss_r, steps_r, emit_r;
  logic [AW-1:0] start_idx_r, p_idx_r, q_idx_r;
  logic signed [CB-1:0] min_y_r, start_x_r, p_x_r, p_y_r, q_x_r, q_y_r;
  logic signed [DW-1:0] dq_x_r, dq_y_r;

  logic                          out_valid_r;
  logic [IW-1:0]                 out_idx_r;
  logic [chgw_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_end_r;

  logic signed [CB-1:0] in_x_c, in_y_c, rd_x, rd_y;
  logic in_xfer, out_xfer, store_ok, out_free, replace, issue, scan_done;
  logic closed, steps_full, emit_last;
  logic [CW-1:0] n_after, p_inc;
  logic [AW-1:0] q_first, pt_rd_addr;

  logic [PTW-1:0] pt_rd;
  logic [AW-1:0]  hb_rd;

  chgw_pkg::scan_ctl_t  ctl;
  chgw_pkg::scan_stat_t stat;
  logic [AW-1:0]        res_idx;
  logic signed [CB-1:0] res_x, res_y;
  logic signed [DW-1:0] res_dx, res_dy;

  // Handshakes and coordinate narrowing to the internal width.
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign out_xfer    = out_valid_r & out_ch.ready;
  assign out_free    = !out_valid_r | out_ch.ready;
  assign in_x_c      = CB'(in_ch.x);
  assign in_y_c      = CB'(in_ch.y);
  assign store_ok    = count_r < CW'(MAX_POINTS);
  assign n_after     = count_r + CW'(store_ok);

  assign rd_x = pt_rd[CB-1:0];
  assign rd_y = pt_rd[PTW-1:CB];

  // Scan control: issue one read per cycle, restart after a replacement.
  assign replace    = stat.valid & stat.cw;
  assign issue      = (state_r == S_SCAN) && !replace && (iss_r < n_r);
  assign scan_done  = (state_r == S_SCAN) && (iss_r == n_r) && !stat.busy;
  assign ctl.issue  = issue;
  assign ctl.flush  = replace;

  // First candidate is the point after p, wrapping at n.
  assign p_inc   = CW'(p_idx_r) + CW'(1);
  assign q_first = (p_inc == n_r) ? '0 : p_inc[AW-1:0];

  assign closed     = (q_idx_r == start_idx_r);
  assign steps_full = (steps_r == CW'(MAX_POINTS));
  assign emit_last  = (CW'(emit_r + CW'(1)) == steps_r);

  assign pt_rd_addr = (state_r == S_VTX) ? q_first : iss_r[AW-1:0];

  chgw_ram #(
    .WIDTH (PTW),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk     (clk),
    .wr_en   (in_xfer & store_ok),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_y_c, in_x_c}),
    .rd_en   (issue | (state_r == S_VTX)),
    .rd_addr (pt_rd_addr),
    .rd_data (pt_rd)
  );

  chgw_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_POINTS)
  ) u_hull_buf (
    .clk     (clk),
    .wr_en   (state_r == S_VTX),
    .wr_addr (steps_r[AW-1:0]),
    .wr_data (p_idx_r),
    .rd_en   (state_r == S_ERD),
    .rd_addr (emit_r[AW-1:0]),
    .rd_data (hb_rd)
  );

  chgw_turn #(
    .COORD_BITS (CB),
    .AW         (AW)
  ) u_turn (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .iss_idx (iss_r[AW-1:0]),
    .pt_data (pt_rd),
    .p_x     (p_x_r),
    .p_y     (p_y_r),
    .dq_x    (dq_x_r),
    .dq_y    (dq_y_r),
    .stat    (stat),
    .res_idx (res_idx),
    .res_x   (res_x),
    .res_y   (res_y),
    .res_dx  (res_dx),
    .res_dy  (res_dy)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer && in_ch.last) begin
          state_nxt = (n_after < CW'(chgw_pkg::MIN_POINTS)) ? S_FEW : S_INIT;
        end
      end
      S_FEW, S_OPEN: begin
        if (out_free) begin
          state_nxt = S_LOAD;
        end
      end
      S_INIT: state_nxt = S_VTX;
      S_VTX:  state_nxt = S_QLD;
      S_QLD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          if (closed) begin
            state_nxt = S_ERD;
          end else if (steps_full) begin
            state_nxt = S_OPEN;
          end else begin
            state_nxt = S_VTX;
          end
        end
      end
      S_ERD: state_nxt = S_EPUT;
      S_EPUT: begin
        if (out_free) begin
          state_nxt = emit_last ? S_LOAD : S_ERD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers: state, counters and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      n_r         <= '0;
      iss_r       <= '0;
      steps_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        count_r <= n_after;
        if (in_ch.last) begin
          n_r     <= n_after;
          count_r <= '0;
        end
      end
      if (state_r == S_INIT) begin
        steps_r <= '0;
      end
      if (state_r == S_VTX) begin
        steps_r <= steps_r + CW'(1);
      end
      if (state_r == S_QLD) begin
        iss_r <= '0;
      end
      if (replace) begin
        iss_r <= CW'(res_idx) + CW'(1);
      end else if (issue) begin
        iss_r <= iss_r + CW'(1);
      end
      if (scan_done) begin
        emit_r <= '0;
      end
      if (state_r == S_EPUT && out_free) begin
        emit_r <= emit_r + CW'(1);
      end
      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_FEW || state_r == S_OPEN || state_r == S_EPUT) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Walk registers: lowest point, edge ends p and q, offset of q from p.
  always_ff @(posedge clk) begin
    if (in_xfer && store_ok && (count_r == '0 || in_y_c < min_y_r)) begin
      min_y_r     <= in_y_c;
      start_x_r   <= in_x_c;
      start_idx_r <= count_r[AW-1:0];
    end
    if (state_r == S_INIT) begin
      p_idx_r <= start_idx_r;
      p_x_r   <= start_x_r;
      p_y_r   <= min_y_r;
    end
    if (state_r == S_VTX) begin
      q_idx_r <= q_first;
    end
    if (state_r == S_QLD) begin
      q_x_r  <= rd_x;
      q_y_r  <= rd_y;
      dq_x_r <= DW'(rd_x) - DW'(p_x_r);
      dq_y_r <= DW'(rd_y) - DW'(p_y_r);
    end
    if (replace) begin
      q_idx_r <= res_idx;
      q_x_r   <= res_x;
      q_y_r   <= res_y;
      dq_x_r  <= res_dx;
      dq_y_r  <= res_dy;
    end
    if (scan_done) begin
      p_idx_r <= q_idx_r;
      p_x_r   <= q_x_r;
      p_y_r   <= q_y_r;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state_r == S_FEW) begin
        out_idx_r    <= '0;
        out_status_r <= chgw_pkg::ST_FEW;
        out_end_r    <= 1'b1;
      end else if (state_r == S_OPEN) begin
        out_idx_r    <= '0;
        out_status_r <= chgw_pkg::ST_OPEN;
        out_end_r    <= 1'b1;
      end else if (state_r == S_EPUT) begin
        out_idx_r    <= IW'(hb_rd);
        out_status_r <= chgw_pkg::ST_OK;
        out_end_r    <= emit_last;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_index = out_idx_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.end_of_hull  = out_end_r;

  // A pipeline result always refers to a loaded point.
  a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.valid |-> (CW'(res_idx) < n_r))
    else $error("turn result index beyond point count");

  // The scan never issues past the last point.
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= n_r))
    else $error("scan index beyond point count");

  // The walk never records more vertices than the buffer holds.
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VTX) |-> (steps_r < CW'(MAX_POINTS)))
    else $error("hull buffer overrun");

  // A status result is always alone, closes the set and carries index zero.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != chgw_pkg::ST_OK) |-> (out_end_r && out_idx_r == '0))
    else $error("status result malformed");

endmodule

`default_nettype wire

// File: tb/tb_convex_hull_gift_wrap.sv
// Self-checking testbench for the gift-wrapping convex hull block.
// Streams point sets with random handshake idling and checks every hull result
// against a behavioral hull walk; depends on chgw_pkg, chgw_if and the block's RTL.
`timescale 1ns / 1ps

module tb_convex_hull_gift_wrap;

  localparam int MAX_PTS        = chgw_pkg::MAX_POINTS_DEF;
  localparam int CBITS          = chgw_pkg::COORD_BITS_DEF;
  localparam int ITEM_TARGET    = 380;
  localparam int IDLE_LIMIT     = 100000;
  localparam int TAIL_CYCLES    = 400;
  localparam int LONG_HOLD      = 700;
  localparam int HOLD_AT_RESULT = 120;

  typedef logic signed [chgw_pkg::FIELD_W-1:0] field_t;

  typedef struct {
    field_t x;
    field_t y;
    logic   last;
    int     gap;
    bit     drain_first;
  } point_item_t;

  typedef struct packed {
    logic [chgw_pkg::IDX_W-1:0]    vertex_index;
    logic [chgw_pkg::STATUS_W-1:0] status;
    logic                          end_of_hull;
  } hull_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_LIGHT, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  chgw_in_if  pt_ch ();
  chgw_out_if hull_ch ();

  convex_hull_gift_wrap u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pt_ch),
    .out_ch (hull_ch)
  );

  point_item_t  point_queue[$];
  hull_result_t hull_expect[$];

  // Shadow of the block's point store for the current set.
  longint held_x[MAX_PTS];
  longint held_y[MAX_PTS];
  int     held_count = 0;

  int fail_count  = 0;
  int sets_sent   = 0;
  int points_sent = 0;
  int results_chk = 0;
  int few_seen    = 0;
  int open_seen   = 0;

  // Stimulus shaping state.
  bit steady_set  = 1'b0;
  int burst_left  = 0;

  // Driver state.
  bit          offering  = 1'b0;
  bit          have_item = 1'b0;
  point_item_t cur_item;
  int          gap_left  = 0;

  // Receiver state.
  rx_mode_t    rx_mode    = RX_OPEN;
  int          mode_left  = 0;
  logic [31:0] stall_bits = '1;
  int          hold_left  = 0;
  bit          hold_done  = 1'b0;
  int          taken      = 0;
  bit          accept;

  int idle_cycles = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // A field is taken as a COORD_BITS-bit two's complement value.
  function automatic longint to_coord(field_t f);
    logic signed [CBITS-1:0] c;
    c = f;
    return longint'(c);
  endfunction

  // Jarvis march over the first n points; yields the result items of the set.
  function automatic void wrap_hull(input longint px[MAX_PTS], input longint py[MAX_PTS],
                                    input int n, output hull_result_t found[$]);
    int           first;
    int           here;
    int           cand;
    int           steps;
    bit           closed;
    int           trail[$];
    hull_result_t r;
    longint       cr;
    found = {};
    if (n < chgw_pkg::MIN_POINTS) begin
      r.vertex_index = '0;
      r.status       = chgw_pkg::ST_FEW;
      r.end_of_hull  = 1'b1;
      found = {found, r};
      return;
    end
    // Lowest y starts the walk; the earliest point wins a tie.
    first = 0;
    for (int i = 1; i < n; i++) begin
      if (py[i] < py[first]) first = i;
    end
    here   = first;
    steps  = 0;
    closed = 1'b0;
    while (steps < MAX_PTS && !closed) begin
      trail = {trail, here};
      steps++;
      cand = (here + 1) % n;
      // Any point with a strictly clockwise turn here,i,cand takes over.
      for (int i = 0; i < n; i++) begin
        cr = (px[i] - px[here]) * (py[cand] - py[here]) -
             (px[cand] - px[here]) * (py[i] - py[here]);
        if (cr < 0) cand = i;
      end
      here = cand;
      if (here == first) closed = 1'b1;
    end
    if (!closed) begin
      r.vertex_index = '0;
      r.status       = chgw_pkg::ST_OPEN;
      r.end_of_hull  = 1'b1;
      found = {found, r};
      return;
    end
    foreach (trail[i]) begin
      r.vertex_index = chgw_pkg::IDX_W'(trail[i]);
      r.status       = chgw_pkg::ST_OK;
      r.end_of_hull  = (i == trail.size() - 1);
      found = {found, r};
    end
  endfunction

  // Updates the shadow store with one accepted point and queues any hull results.
  function automatic void absorb_point(field_t x, field_t y, logic last);
    hull_result_t found[$];
    if (held_count < MAX_PTS) begin
      held_x[held_count] = to_coord(x);
      held_y[held_count] = to_coord(y);
      held_count++;
    end
    if (last) begin
      wrap_hull(held_x, held_y, held_count, found);
      foreach (found[i]) hull_expect = {hull_expect, found[i]};
      held_count = 0;
    end
  endfunction

  function automatic field_t rand_coord(int spread);
    if (spread == 0) return field_t'($urandom);
    return field_t'(int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Appends one point; the idle gap before it follows the current burst pattern.
  function automatic void queue_point(field_t x, field_t y, logic last, bit drain);
    point_item_t it;
    it.x           = x;
    it.y           = y;
    it.last        = last;
    it.drain_first = drain;
    if (steady_set) begin
      it.gap = 0;
    end else if (burst_left > 0) begin
      burst_left--;
      it.gap = 0;
    end else begin
      burst_left = $urandom_range(1, 16);
      it.gap     = $urandom_range(1, 10);
    end
    point_queue = {point_queue, it};
  endfunction

  // Stimulus: directed sets first, then random sets, then wait for the last results.
  initial begin
    int  kind;
    int  n;
    int  spread;
    bit  drain;
    bit  first_random;
    rst_n        = 1'b0;
    pt_ch.valid  = 1'b0;
    pt_ch.x      = '0;
    pt_ch.y      = '0;
    pt_ch.last   = 1'b0;
    hull_ch.ready = 1'b0;

    // Single point and two points: too few for a hull.
    queue_point(16'sd0, 16'sd0, 1'b1, 1'b0);
    queue_point(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    queue_point(16'sd32767, 16'sd32767, 1'b1, 1'b0);

    // Corners of the coordinate range with an interior point.
    queue_point(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    queue_point(16'sd32767, -16'sd32768, 1'b0, 1'b0);
    queue_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    queue_point(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    queue_point(-16'sd32768, 16'sd32767, 1'b1, 1'b0);

    // A later copy of the start point traps the walk in a loop that never closes.
    queue_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    queue_point(16'sd1, 16'sd1, 1'b0, 1'b0);
    queue_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    queue_point(-16'sd1, 16'sd1, 1'b1, 1'b0);

    // All points on one line.
    queue_point(16'sd0, 16'sd5, 1'b0, 1'b0);
    queue_point(16'sd10, 16'sd5, 1'b0, 1'b0);
    queue_point(16'sd20, 16'sd5, 1'b1, 1'b0);

    // Full store on a parabola, so every point is a hull vertex; the two extra
    // points would change the hull if they were not dropped.
    for (int k = 0; k < MAX_PTS; k++) begin
      queue_point(field_t'(k * 400 - 12800), field_t'(k * k * 8), 1'b0, 1'b0);
    end
    queue_point(16'sd30000, -16'sd30000, 1'b0, 1'b0);
    queue_point(-16'sd30000, -16'sd30000, 1'b1, 1'b0);

    // Random sets: mostly hulls of a handful of points, some degenerate grids,
    // a few tiny or oversized sets.
    first_random = 1'b1;
    while (point_queue.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        n      = $urandom_range(1, 2);
        spread = 0;
      end else if (kind < 5) begin
        n      = $urandom_range(3, 8);
        spread = 2;
      end else if (kind == 5) begin
        n      = $urandom_range(40, 70);
        spread = 0;
      end else begin
        n      = $urandom_range(3, 12);
        spread = ($urandom_range(0, 1) == 0) ? 0 : 1000;
      end
      steady_set   = ($urandom_range(0, 3) == 0);
      drain        = first_random || ($urandom_range(0, 19) == 0);
      first_random = 1'b0;
      for (int i = 0; i < n; i++) begin
        queue_point(rand_coord(spread), rand_coord(spread), i == n - 1, drain && i == 0);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (point_queue.size() != 0 || have_item || hull_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d point sets (%0d points transferred), %0d hull results checked.",
             sets_sent, points_sent, results_chk);
    $display("Status results seen: %0d too-few sets, %0d walks that did not close.",
             few_seen, open_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Point driver: holds each point until its transfer, honoring gaps and drain pauses.
  always @(posedge clk) begin
    if (!rst_n) begin
      pt_ch.valid <= 1'b0;
    end else begin
      if (offering && pt_ch.ready) begin
        absorb_point(cur_item.x, cur_item.y, cur_item.last);
        points_sent++;
        if (cur_item.last) sets_sent++;
        offering  = 1'b0;
        have_item = 1'b0;
      end
      if (!have_item && point_queue.size() > 0 &&
          !(point_queue[0].drain_first && hull_expect.size() > 0)) begin
        cur_item  = point_queue.pop_front();
        have_item = 1'b1;
        gap_left  = cur_item.gap;
      end
      if (have_item && !offering) begin
        if (gap_left > 0) gap_left--;
        else offering = 1'b1;
      end
      pt_ch.valid <= offering;
      pt_ch.x     <= cur_item.x;
      pt_ch.y     <= cur_item.y;
      pt_ch.last  <= cur_item.last;
    end
  end

  // Result receiver: changes its stall mode now and then, and holds off once for
  // a long stretch so the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hull_ch.ready <= 1'b0;
    end else begin
      if (hull_ch.valid && hull_ch.ready) taken++;
      if (!hold_done && taken >= HOLD_AT_RESULT) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 160);
        stall_bits = $urandom;
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        accept = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:  accept = 1'b1;
          RX_COIN:  accept = $urandom_range(0, 1);
          RX_LIGHT: accept = ($urandom_range(0, 3) != 0);
          default: begin
            accept     = stall_bits[0];
            stall_bits = {stall_bits[0], stall_bits[31:1]};
          end
        endcase
      end
      hull_ch.ready <= accept;
    end
  end

  // Result monitor: each transfer is checked against the oldest expected result.
  always @(posedge clk) begin
    hull_result_t want;
    if (rst_n && hull_ch.valid && hull_ch.ready) begin
      if (hull_expect.size() == 0) begin
        $error("unexpected result: vertex_index %0d status %0d end_of_hull %0d",
               hull_ch.vertex_index, hull_ch.status, hull_ch.end_of_hull);
        fail_count++;
      end else begin
        want = hull_expect.pop_front();
        results_chk++;
        if (want.status == chgw_pkg::ST_FEW) few_seen++;
        if (want.status == chgw_pkg::ST_OPEN) open_seen++;
        if (hull_ch.vertex_index !== want.vertex_index) begin
          $error("vertex_index mismatch: expected %0d, got %0d",
                 want.vertex_index, hull_ch.vertex_index);
          fail_count++;
        end
        if (hull_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, hull_ch.status);
          fail_count++;
        end
        if (hull_ch.end_of_hull !== want.end_of_hull) begin
          $error("end_of_hull mismatch: expected %0d, got %0d",
                 want.end_of_hull, hull_ch.end_of_hull);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (pt_ch.valid && pt_ch.ready) || (hull_ch.valid && hull_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
